// ----- rtl/crd_pkg.sv -----
// Shared types, constants and status codes for the chunk reassembly deframer.
// No dependencies; used by the header check, the top level and the checker.
`default_nettype none

package crd_pkg;

  // chunk framing
  localparam int HDR_LEN         = 8;
  localparam int MAX_CHUNK_BYTES = 260;
  localparam int FLAG_START_BIT  = 0;
  localparam int FLAG_END_BIT    = 1;

  // widths
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 9;
  localparam int CNT_W  = 18;
  localparam int SEQ_W  = 16;
  localparam int ERR_W  = 3;

  // message buffer size, also the ceiling on max_body
  localparam logic [CNT_W-1:0] BUF_LIMIT = CNT_W'(192 * 1024);

  // message types that are accepted
  localparam logic [BYTE_W-1:0] MSG_TYPE_MIN = 8'd1;
  localparam logic [BYTE_W-1:0] MSG_TYPE_MAX = 8'd4;

  // result status
  typedef enum logic [ERR_W-1:0] {
    ERR_OK           = 3'd0,
    ERR_TOTAL_LARGE  = 3'd1,
    ERR_UNEXP_CONT   = 3'd2,
    ERR_OVERFLOW     = 3'd3,
    ERR_LEN_MISMATCH = 3'd4,
    ERR_UNKNOWN_TYPE = 3'd5
  } err_t;

  // 8-byte little-endian header; type sits in the lowest byte
  typedef struct packed {
    logic [31:0]       total;
    logic [SEQ_W-1:0]  seq;
    logic [BYTE_W-1:0] flags;
    logic [BYTE_W-1:0] msg_type;
  } hdr_t;

  // open message status seen by the header check
  typedef struct packed {
    logic              in_message;
    logic [BYTE_W-1:0] open_type;
    logic [SEQ_W-1:0]  open_sequence;
    logic [CNT_W-1:0]  bytes_collected;
  } open_msg_t;

endpackage

`default_nettype wire

// ----- rtl/crd_hdr_check.sv -----
// Header check for one chunk: start limits, continuation match and body overflow.
// Depends on crd_pkg for the header, open message status and error codes.
`default_nettype none

module crd_hdr_check
  import crd_pkg::*;
(
  input  hdr_t             hdr,
  input  open_msg_t        open_msg,
  input  logic [LEN_W-1:0] chunk_bytes,
  input  logic [CNT_W-1:0] limit,
  output err_t             err
);

  logic [LEN_W-1:0] plen;
  logic             total_big;
  logic             plen_big;
  logic [CNT_W:0]   cont_sum;
  logic             cont_big;
  logic             cont_mismatch;

  // payload bytes in this chunk
  assign plen = chunk_bytes - LEN_W'(HDR_LEN);

  // compares against the effective limit
  assign total_big     = (|hdr.total[31:CNT_W]) || (hdr.total[CNT_W-1:0] > limit);
  assign plen_big      = {{(CNT_W-LEN_W){1'b0}}, plen} > limit;
  assign cont_sum      = {1'b0, open_msg.bytes_collected} + {{(CNT_W+1-LEN_W){1'b0}}, plen};
  assign cont_big      = cont_sum > {1'b0, limit};
  assign cont_mismatch = !open_msg.in_message ||
                         (open_msg.open_type != hdr.msg_type) ||
                         (open_msg.open_sequence != hdr.seq);

  // start chunks and continuations are judged differently
  always_comb begin
    if (hdr.flags[FLAG_START_BIT]) begin
      priority if (total_big) err = ERR_TOTAL_LARGE;
      else if (plen_big)      err = ERR_OVERFLOW;
      else                    err = ERR_OK;
    end else begin
      priority if (cont_mismatch) err = ERR_UNEXP_CONT;
      else if (cont_big)          err = ERR_OVERFLOW;
      else                        err = ERR_OK;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/chunk_reassembly_deframer.sv -----
// Chunk reassembly deframer: one chunk byte in, one result out per request.
// Depends on crd_pkg and crd_hdr_check.
`default_nettype none

// Takes one byte of a link chunk per request, with the length of its chunk,
// and returns exactly one result per request. Each chunk opens with an 8-byte
// little-endian header (type, flags, sequence, total length) that is checked
// on its eighth byte; payload bytes then come out as buffer write address and
// data (out_tuser high), and the last byte of a chunk that ends a message or
// fails carries the report (out_tlast high, with type, length and status).
// A byte passes an input register and a result register: it is accepted every
// cycle while results are taken; its result enters the result register as it
// leaves the input register, held there while the result side stalls. All
// per-byte work is one pass of logic on the framing state; only a stall holds
// the rate under one byte per clock. The limit register (cfg_wr_data, taken when
// cfg_wr_en is high) should be written only while no request is in flight.
module chunk_reassembly_deframer
  import crd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,   // byte_value[7:0], chunk_length[16:8], zero pad

  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [55:0]       out_tdata,  // write_address[17:0], write_data[25:18],
                                        // message_type[33:26], message_length[51:34],
                                        // error_code[54:52], zero pad
  output logic              out_tlast,  // message_done
  output logic [0:0]        out_tuser,  // write_valid

  input  logic              cfg_wr_en,
  input  logic [CNT_W-1:0]  cfg_wr_data  // max_body
);

  // input register
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic [LEN_W-1:0]  s1_len_r;
  logic              adv;

  // framing state
  logic [CNT_W-1:0]  max_body_r;
  logic              in_message_r,      in_message_nxt;
  logic [BYTE_W-1:0] open_type_r,       open_type_nxt;
  logic [SEQ_W-1:0]  open_sequence_r,   open_sequence_nxt;
  logic [CNT_W-1:0]  expected_total_r,  expected_total_nxt;
  logic [CNT_W-1:0]  bytes_collected_r, bytes_collected_nxt;
  logic [LEN_W-1:0]  byte_position_r,   byte_position_nxt;
  hdr_t              header_r,          header_nxt;
  logic              chunk_discard_r,   chunk_discard_nxt;

  // result register
  logic              out_valid_r;
  logic              wr_valid_r,  wr_valid_nxt;
  logic [CNT_W-1:0]  wr_addr_r,   wr_addr_nxt;
  logic [BYTE_W-1:0] wr_data_r,   wr_data_nxt;
  logic              done_r,      done_nxt;
  logic [BYTE_W-1:0] msg_type_r,  msg_type_nxt;
  logic [CNT_W-1:0]  msg_len_r,   msg_len_nxt;
  err_t              err_r,       err_nxt;

  // per-byte decode
  logic [LEN_W-1:0]  len;
  logic              ignored;
  logic              last;
  logic [LEN_W:0]    pos_inc;
  logic [63:0]       hdr_base;
  logic              in_header;
  logic              at_check;
  logic              past_header;
  logic [CNT_W-1:0]  limit;
  open_msg_t         open_msg;
  err_t              chk_err;
  err_t              end_err;

  // pipeline handshake
  assign adv        = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || adv;
  assign out_tvalid = out_valid_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata[7:0];
      s1_len_r  <= in_tdata[16:8];
    end
  end

  // limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_body_r <= BUF_LIMIT;
    end else if (cfg_wr_en) begin
      max_body_r <= cfg_wr_data;
    end
  end

  assign limit = (max_body_r > BUF_LIMIT) ? BUF_LIMIT : max_body_r;

  // chunk position decode
  assign len         = (s1_len_r == '0) ? LEN_W'(1) : s1_len_r;
  assign ignored     = (len < LEN_W'(HDR_LEN)) ||
                       ({1'b0, len} > (LEN_W+1)'(MAX_CHUNK_BYTES));
  assign pos_inc     = {1'b0, byte_position_r} + (LEN_W+1)'(1);
  assign last        = pos_inc >= {1'b0, len};
  assign in_header   = byte_position_r < LEN_W'(HDR_LEN);
  assign at_check    = byte_position_r == LEN_W'(HDR_LEN - 1);
  assign past_header = !in_header;

  // header assembly, the current byte merged in
  assign hdr_base = (byte_position_r == '0) ? 64'd0 : header_r;
  always_comb begin
    if (in_header) begin
      header_nxt = hdr_t'(hdr_base |
                          (64'(s1_byte_r) << {byte_position_r[2:0], 3'b000}));
    end else begin
      header_nxt = header_r;
    end
  end

  // header check against the state before this byte
  assign open_msg = '{in_message:      in_message_r,
                      open_type:       open_type_r,
                      open_sequence:   open_sequence_r,
                      bytes_collected: bytes_collected_r};

  crd_hdr_check u_hdr_check (
    .hdr         (header_nxt),
    .open_msg    (open_msg),
    .chunk_bytes (len),
    .limit       (limit),
    .err         (chk_err)
  );

  // framing state update and result for one byte
  always_comb begin
    in_message_nxt      = in_message_r;
    open_type_nxt       = open_type_r;
    open_sequence_nxt   = open_sequence_r;
    expected_total_nxt  = expected_total_r;
    bytes_collected_nxt = bytes_collected_r;
    chunk_discard_nxt   = (byte_position_r == '0) ? 1'b1 : chunk_discard_r;
    byte_position_nxt   = last ? '0 : pos_inc[LEN_W-1:0];
    wr_valid_nxt        = 1'b0;
    wr_addr_nxt         = '0;
    wr_data_nxt         = '0;
    done_nxt            = 1'b0;
    msg_type_nxt        = '0;
    msg_len_nxt         = '0;
    err_nxt             = ERR_OK;
    end_err             = ERR_OK;

    if (!ignored) begin
      // header check on the eighth byte, or payload write
      if (at_check) begin
        chunk_discard_nxt = (chk_err != ERR_OK);
        if (chk_err == ERR_OK && header_nxt.flags[FLAG_START_BIT]) begin
          open_type_nxt       = header_nxt.msg_type;
          open_sequence_nxt   = header_nxt.seq;
          expected_total_nxt  = header_nxt.total[CNT_W-1:0];
          bytes_collected_nxt = '0;
          in_message_nxt      = 1'b1;
        end
      end else if (past_header && !chunk_discard_nxt) begin
        wr_valid_nxt        = 1'b1;
        wr_addr_nxt         = bytes_collected_r;
        wr_data_nxt         = s1_byte_r;
        bytes_collected_nxt = bytes_collected_r + CNT_W'(1);
      end

      // end of message status
      if (expected_total_nxt != '0 && bytes_collected_nxt != expected_total_nxt) begin
        end_err = ERR_LEN_MISMATCH;
      end else if (open_type_nxt >= MSG_TYPE_MIN && open_type_nxt <= MSG_TYPE_MAX) begin
        end_err = ERR_OK;
      end else begin
        end_err = ERR_UNKNOWN_TYPE;
      end

      // report on the last byte of the chunk
      if (last && (at_check || past_header)) begin
        if (chunk_discard_nxt) begin
          if (chk_err != ERR_OK) begin
            done_nxt            = 1'b1;
            msg_type_nxt        = header_nxt.msg_type;
            err_nxt             = chk_err;
            in_message_nxt      = 1'b0;
            bytes_collected_nxt = '0;
            expected_total_nxt  = '0;
          end
        end else if (header_nxt.flags[FLAG_END_BIT]) begin
          done_nxt            = 1'b1;
          msg_type_nxt        = open_type_nxt;
          msg_len_nxt         = bytes_collected_nxt;
          err_nxt             = end_err;
          in_message_nxt      = 1'b0;
          bytes_collected_nxt = '0;
          expected_total_nxt  = '0;
        end
      end
    end
  end

  // framing state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_message_r      <= 1'b0;
      open_type_r       <= '0;
      open_sequence_r   <= '0;
      expected_total_r  <= '0;
      bytes_collected_r <= '0;
      byte_position_r   <= '0;
      header_r          <= '0;
      chunk_discard_r   <= 1'b0;
    end else if (adv) begin
      in_message_r      <= in_message_nxt;
      open_type_r       <= open_type_nxt;
      open_sequence_r   <= open_sequence_nxt;
      expected_total_r  <= expected_total_nxt;
      bytes_collected_r <= bytes_collected_nxt;
      byte_position_r   <= byte_position_nxt;
      header_r          <= header_nxt;
      chunk_discard_r   <= chunk_discard_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wr_valid_r <= wr_valid_nxt;
      wr_addr_r  <= wr_addr_nxt;
      wr_data_r  <= wr_data_nxt;
      done_r     <= done_nxt;
      msg_type_r <= msg_type_nxt;
      msg_len_r  <= msg_len_nxt;
      err_r      <= err_nxt;
    end
  end

  // output packing
  assign out_tdata = {1'b0, err_r, msg_len_r, msg_type_r, wr_data_r, wr_addr_r};
  assign out_tlast = done_r;
  assign out_tuser = wr_valid_r;

endmodule

`default_nettype wire

// ----- rtl/crd_checker.sv -----
// Port-level checker for the chunk reassembly deframer, bound to the top level.
// Depends on crd_pkg for the status codes.
`default_nettype none

module crd_checker
  import crd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        out_tlast,
  input logic [0:0]  out_tuser
);

  logic [ERR_W-1:0] err_f;
  assign err_f = out_tdata[54:52];

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tlast) && $stable(out_tuser))
    else $error("result changed while stalled");

  // no report fields without a report
  a_no_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[54:26] == '0)
    else $error("report fields set without message_done");

  // no write fields without a write
  a_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[25:0] == '0)
    else $error("write fields set without write_valid");

  // header failures carry no length and no write
  a_fail_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast &&
    (err_f == ERR_TOTAL_LARGE || err_f == ERR_UNEXP_CONT || err_f == ERR_OVERFLOW)
    |-> out_tdata[51:34] == '0 && !out_tuser[0])
    else $error("failed chunk reported a length or a write");

  // status stays within the defined codes
  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> err_f <= ERR_UNKNOWN_TYPE && !out_tdata[55])
    else $error("undefined status code");

endmodule

bind chunk_reassembly_deframer crd_checker u_crd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire
